// ===== design/tds_pkg.sv =====
// shared constants, command codes and controller/datapath link types of the dependency scoreboard
package tds_pkg;

  localparam int TASK_IDS = 64;
  localparam int IDX_W    = (TASK_IDS > 1) ? $clog2(TASK_IDS) : 1;
  localparam int ID_W     = 6;
  localparam int MASK_W   = 64;
  localparam int CMD_W    = 3;
  localparam int CNT_W    = 7;

  localparam logic [CMD_W-1:0] CMD_ASSIGN   = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ADD      = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_COMPLETE = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_GET_RDY  = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_HAS_PEND = CMD_W'(4);
  localparam logic [CMD_W-1:0] CMD_CANCEL   = CMD_W'(5);

  // controller to datapath commands
  typedef struct packed {
    logic             accept;     // item taken this cycle
    logic             simple;     // item finishes at once, result from the inputs
    logic             row_id_rd;  // read dependents row of the item's slot
    logic             sweep;      // slot sweep, first stage at idx
    logic [IDX_W-1:0] idx;
    logic             fin;        // last cycle of a long command
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic id_ok;
    logic mask_nz;
  } dp_stat_t;

endpackage

// ===== design/tds_ctrl.sv =====
// command sequencer: idle, row fetch, slot sweep, drain and finish states
module tds_ctrl import tds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd_i,
  input  dp_stat_t         stat_i,
  output logic             busy,
  output dp_ctrl_t         ctrl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROW   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_IDS - 1);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  logic             long_go;

  assign accept  = start && (state_q == ST_IDLE);
  assign long_go = ((cmd_i == CMD_ADD) && stat_i.id_ok && stat_i.mask_nz) ||
                   ((cmd_i == CMD_COMPLETE) && stat_i.id_ok) ||
                   (cmd_i == CMD_GET_RDY);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && long_go) begin
          state_d = (cmd_i == CMD_COMPLETE) ? ST_ROW : ST_SWEEP;
          idx_d   = '0;
        end
      end
      ST_ROW: begin
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_LAST) begin
          state_d = ST_TAIL;
          idx_d   = '0;
        end
      end
      ST_TAIL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign ctrl_o.accept    = accept;
  assign ctrl_o.simple    = accept && !long_go;
  assign ctrl_o.row_id_rd = (state_q == ST_ROW);
  assign ctrl_o.sweep     = (state_q == ST_SWEEP);
  assign ctrl_o.idx       = idx_q;
  assign ctrl_o.fin       = (state_q == ST_FIN);

endmodule

// ===== design/tds_dp.sv =====
// scoreboard datapath: slot flags, count and dependents stores, sweep pipeline, result register
module tds_dp import tds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_ctrl_t          ctrl_i,
  output dp_stat_t          stat_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [MASK_W-1:0] dep_mask_i,
  output logic              out_valid_o,
  output logic [ID_W-1:0]   out_task_id_o,
  output logic              hit_o,
  output logic              was_cancelled_o,
  output logic              last_o
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_IDS - 1);

  // latched item
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    id_q;
  logic [TASK_IDS-1:0] mask_q;

  // slot state
  logic [IDX_W-1:0]    next_q, next_d;
  logic [TASK_IDS-1:0] pend_q, pend_d;
  logic [TASK_IDS-1:0] canc_q, canc_d;
  logic [TASK_IDS-1:0] row_vld_q, row_vld_d;

  logic [CNT_W-1:0]    count_mem [TASK_IDS];
  logic [TASK_IDS-1:0] row_mem   [TASK_IDS];

  // sweep pipeline
  logic [CNT_W-1:0]    cnt_rd_q;
  logic [TASK_IDS-1:0] row_rd_q;
  logic                row_v_q;
  logic                b_vld_q;
  logic [IDX_W-1:0]    b_idx_q;
  logic [CNT_W-1:0]    acc_q;

  // get-ready hold slot, so the final release can carry last
  logic                held_v_q, held_v_d;
  logic [IDX_W-1:0]    held_id_q, held_id_d;
  logic                held_c_q, held_c_d;

  // result register
  logic                vld_q, vld_d;
  logic [ID_W-1:0]     oid_q, oid_d;
  logic                hit_q, hit_d;
  logic                oc_q, oc_d;
  logic                last_q, last_d;

  logic [IDX_W-1:0]    id_in;
  logic [TASK_IDS-1:0] mask_in;
  logic                id_ok;
  logic [TASK_IDS-1:0] row_cur;
  logic [TASK_IDS-1:0] id_bit;
  logic [IDX_W-1:0]    row_addr;
  logic                row_re;
  logic                row_we;
  logic                dec;
  logic                add_fin;
  logic                rdy_hit;
  logic                cnt_we;
  logic [IDX_W-1:0]    cnt_wa;
  logic [CNT_W-1:0]    cnt_wd;

  assign id_in   = task_id_i[IDX_W-1:0];
  assign mask_in = dep_mask_i[TASK_IDS-1:0];
  assign id_ok   = ((ID_W+1)'(task_id_i) < (ID_W+1)'(TASK_IDS));

  assign stat_o.id_ok   = id_ok;
  assign stat_o.mask_nz = |mask_in;

  assign row_cur  = row_v_q ? row_rd_q : '0;
  assign id_bit   = TASK_IDS'(1) << id_q;
  assign row_addr = ctrl_i.row_id_rd ? id_q : ctrl_i.idx;
  assign row_re   = ctrl_i.row_id_rd || (ctrl_i.sweep && (cmd_q == CMD_ADD));

  assign row_we  = b_vld_q && (cmd_q == CMD_ADD) && mask_q[b_idx_q];
  assign dec     = b_vld_q && (cmd_q == CMD_COMPLETE) && row_cur[b_idx_q] &&
                   pend_q[b_idx_q] && (cnt_rd_q != '0);
  assign add_fin = ctrl_i.fin && (cmd_q == CMD_ADD);
  assign rdy_hit = b_vld_q && (cmd_q == CMD_GET_RDY) && pend_q[b_idx_q] &&
                   (cnt_rd_q == '0);

  assign cnt_we = dec || add_fin;
  assign cnt_wa = add_fin ? id_q : b_idx_q;
  assign cnt_wd = add_fin ? acc_q : (cnt_rd_q - CNT_W'(1));

  // count store
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    if (ctrl_i.sweep) begin
      cnt_rd_q <= count_mem[ctrl_i.idx];
    end
  end

  // dependents store, rows past their valid bit read as zero
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[b_idx_q] <= row_cur | id_bit;
    end
    if (row_re) begin
      row_rd_q <= row_mem[row_addr];
      row_v_q  <= row_vld_q[row_addr];
    end
  end

  // item fields and sweep stage two
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_i;
      id_q   <= id_in;
      mask_q <= mask_in;
      acc_q  <= '0;
    end else if (ctrl_i.sweep && (cmd_q == CMD_ADD)) begin
      acc_q <= acc_q + CNT_W'(mask_q[ctrl_i.idx]);
    end
    b_idx_q   <= ctrl_i.idx;
    held_id_q <= held_id_d;
    held_c_q  <= held_c_d;
    oid_q     <= oid_d;
    hit_q     <= hit_d;
    oc_q      <= oc_d;
    last_q    <= last_d;
  end

  always_comb begin
    next_d    = next_q;
    pend_d    = pend_q;
    canc_d    = canc_q;
    row_vld_d = row_vld_q;
    held_v_d  = held_v_q;
    held_id_d = held_id_q;
    held_c_d  = held_c_q;
    vld_d     = 1'b0;
    oid_d     = '0;
    hit_d     = 1'b0;
    oc_d      = 1'b0;
    last_d    = 1'b0;

    if (ctrl_i.accept) begin
      held_v_d = 1'b0;
      if (cmd_i == CMD_ASSIGN) begin
        next_d = (next_q == IDX_LAST) ? '0 : next_q + IDX_W'(1);
      end
      if ((cmd_i == CMD_CANCEL) && id_ok && pend_q[id_in]) begin
        canc_d[id_in] = 1'b1;
      end
    end

    if (ctrl_i.simple) begin
      vld_d  = 1'b1;
      last_d = 1'b1;
      case (cmd_i)
        CMD_ASSIGN:   oid_d = ID_W'(next_q);
        CMD_HAS_PEND: hit_d = |pend_q;
        CMD_CANCEL:   hit_d = id_ok && pend_q[id_in];
        default:      hit_d = 1'b0;
      endcase
    end

    if (row_we) begin
      row_vld_d[b_idx_q] = 1'b1;
    end

    if (add_fin) begin
      pend_d[id_q] = 1'b1;
      canc_d[id_q] = 1'b0;
    end

    if (ctrl_i.fin && (cmd_q == CMD_COMPLETE)) begin
      row_vld_d[id_q] = 1'b0;
    end

    // release: the earlier held slot goes out, the new one waits
    if (rdy_hit) begin
      if (held_v_q) begin
        vld_d = 1'b1;
        oid_d = ID_W'(held_id_q);
        hit_d = 1'b1;
        oc_d  = held_c_q;
      end
      held_v_d        = 1'b1;
      held_id_d       = b_idx_q;
      held_c_d        = canc_q[b_idx_q];
      pend_d[b_idx_q] = 1'b0;
      canc_d[b_idx_q] = 1'b0;
    end

    if (ctrl_i.fin) begin
      vld_d    = 1'b1;
      last_d   = 1'b1;
      held_v_d = 1'b0;
      if ((cmd_q == CMD_GET_RDY) && held_v_q) begin
        oid_d = ID_W'(held_id_q);
        hit_d = 1'b1;
        oc_d  = held_c_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q    <= '0;
      pend_q    <= '0;
      canc_q    <= '0;
      row_vld_q <= '0;
      held_v_q  <= 1'b0;
      b_vld_q   <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      next_q    <= next_d;
      pend_q    <= pend_d;
      canc_q    <= canc_d;
      row_vld_q <= row_vld_d;
      held_v_q  <= held_v_d;
      b_vld_q   <= ctrl_i.sweep;
      vld_q     <= vld_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign out_task_id_o   = oid_q;
  assign hit_o           = hit_q;
  assign was_cancelled_o = oc_q;
  assign last_o          = last_q;

endmodule

// ===== design/task_dependency_scoreboard_top.sv =====
// top level of the task dependency scoreboard: sequencer, datapath and checks
// assign, has-pending, cancel, unused codes, an add with empty mask, an add or complete with
//   bad id answer the cycle after the item is taken with busy low, one item per cycle;
//   the receiver never stalls; add, get-ready sweep all slots (one slot per cycle), complete
//   after a row fetch; final result comes with busy low, when the next item may already be taken
// get-ready holds each ready slot until the next one is found, the last goes with the final
//   result; reset (rst_ni low, async) clears id counter, flags, row valid bits and sequencer
module task_dependency_scoreboard_top import tds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [MASK_W-1:0] dep_mask_i,
  output logic              out_valid_o,
  output logic [ID_W-1:0]   out_task_id_o,
  output logic              hit_o,
  output logic              was_cancelled_o,
  output logic              last_o
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // sequencer: decides simple vs sweep commands and walks the slot index
  tds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // datapath: flags, stores, two-stage sweep and the result register
  tds_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (cmd_i),
    .task_id_i       (task_id_i),
    .dep_mask_i      (dep_mask_i),
    .out_valid_o     (out_valid_o),
    .out_task_id_o   (out_task_id_o),
    .hit_o           (hit_o),
    .was_cancelled_o (was_cancelled_o),
    .last_o          (last_o)
  );

  // a non-final item only comes out while a sweep is still running
  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> busy)
    else $error("non-final result outside a sweep");

  // every long command ends with its final result right as busy drops
  a_fin_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (out_valid_o && last_o))
    else $error("busy dropped without a final result");

  // an id request answers in the next cycle with a single final item, no hit
  a_assign_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_ASSIGN)) |=> (out_valid_o && last_o && !hit_o))
    else $error("assign gave no single result");

endmodule
